// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
// Check that ante implies cons in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that ante implies cons in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body deframer package
// Phase and class codes, character constants, the hex digit decoder and the whitespace test.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	typedef logic [1:0] phase_t;
	typedef logic [2:0] class_t;
	typedef logic [7:0] byte_t;

	// phase codes
	localparam phase_t PH_SIZE = 2'd0;
	localparam phase_t PH_DATA = 2'd1;
	localparam phase_t PH_DONE = 2'd2;
	localparam phase_t PH_ERR  = 2'd3;

	// byte class codes
	localparam class_t CL_SIZE    = 3'd0;
	localparam class_t CL_DATA    = 3'd1;
	localparam class_t CL_FINAL   = 3'd2;
	localparam class_t CL_ERROR   = 3'd3;
	localparam class_t CL_IGNORED = 3'd4;

	localparam byte_t CH_HT    = 8'h09;
	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_0     = 8'h30;
	localparam byte_t CH_9     = 8'h39;
	localparam byte_t CH_UA    = 8'h41;
	localparam byte_t CH_UF    = 8'h46;
	localparam byte_t CH_LA    = 8'h61;
	localparam byte_t CH_LF_HEX = 8'h66;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input byte_t c);
		hex_t r;
		r.valid = 1'b0;
		r.value = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			r.valid = 1'b1;
			r.value = 4'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF_HEX) begin
			r.valid = 1'b1;
			r.value = 4'(c - CH_LA + 8'd10);
		end else if (c >= CH_UA && c <= CH_UF) begin
			r.valid = 1'b1;
			r.value = 4'(c - CH_UA + 8'd10);
		end
		return r;
	endfunction

	function automatic logic is_space(input byte_t c);
		return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

// File: rtl/chunked_body_deframer_core.sv
// ----------------------------------------------------------------------------
// Chunked body deframer core
// Classifies each byte of a chunked HTTP body as size line, payload, final
// LF, error or ignored, and echoes it with that class.
// ----------------------------------------------------------------------------
//  channel  direction  signals                     contents
//  s_*      in         s_tvalid s_tready s_tdata   one raw body byte
//  m_*      out        m_tvalid m_tready m_tdata   echoed byte
//                      m_tuser                     byte class
//
//  One byte per cycle while m_* does not stall: the state update and class
//  decode sit between the input port and the output register.
//  s_tready stays high while the output register is empty or being drained,
//  so a stall on m_* holds at most one byte.
//  arst_n sets phase to size line and the line-start flag, and clears the length.
//  After the final zero chunk or an error, bytes pass as ignored until reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module chunked_body_deframer_core #(
	parameter int LENGTH_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  cbd_pkg::byte_t  s_tdata,   // [7:0] in_byte
	output logic                m_tvalid,
	input  wire                 m_tready,
	output cbd_pkg::byte_t      m_tdata,   // [7:0] out_byte
	output cbd_pkg::class_t     m_tuser    // [2:0] byte_class
);
	import cbd_pkg::*;

	localparam int LB = LENGTH_BITS;

	phase_t        phase_q, phase_d;
	logic          line_start_q, line_start_d;
	logic [LB-1:0] len_q, len_d;
	class_t        cls;
	hex_t          hex;
	logic          ovf;
	logic          s_accept;

	assign s_tready = !m_tvalid || m_tready;
	assign s_accept = s_tvalid && s_tready;

	assign hex = hex_decode(s_tdata);
	// another digit would push the length past LB bits
	assign ovf = |len_q[LB-1:LB-4];

	always_comb begin
		phase_d      = phase_q;
		line_start_d = line_start_q;
		len_d        = len_q;
		cls          = CL_IGNORED;
		unique case (phase_q)
			PH_SIZE: begin
				cls = CL_SIZE;
				priority if (line_start_q && s_tdata == CH_CR) begin
					// skip CR left from the previous chunk
				end else if (line_start_q && s_tdata == CH_LF) begin
					line_start_d = 1'b0;
				end else begin
					line_start_d = 1'b0;
					priority if (s_tdata == CH_LF) begin
						if (len_q == '0) begin
							phase_d = PH_DONE;
							cls     = CL_FINAL;
						end else begin
							phase_d = PH_DATA;
						end
					end else if (is_space(s_tdata)) begin
						// skip whitespace
					end else if (!hex.valid || ovf) begin
						phase_d = PH_ERR;
						cls     = CL_ERROR;
					end else begin
						len_d = {len_q[LB-5:0], hex.value};
					end
				end
			end
			PH_DATA: begin
				cls   = CL_DATA;
				len_d = len_q - LB'(1);
				if (len_q == LB'(1)) begin
					phase_d      = PH_SIZE;
					line_start_d = 1'b1;
				end
			end
			PH_DONE, PH_ERR: begin
				cls = CL_IGNORED;
			end
			default: begin
				cls = CL_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			line_start_q <= 1'b1;
			len_q        <= '0;
		end else if (s_accept) begin
			phase_q      <= phase_d;
			line_start_q <= line_start_d;
			len_q        <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else begin
			m_tvalid <= s_accept || (m_tvalid && !m_tready);
		end
	end

	// output payload, loaded with each accepted item
	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata <= s_tdata;
			m_tuser <= cls;
		end
	end

	`ASSERT_NEXT(a_done_sticky, clk, arst_n, phase_q == PH_DONE, phase_q == PH_DONE)
	`ASSERT_NEXT(a_err_sticky, clk, arst_n, phase_q == PH_ERR, phase_q == PH_ERR)
	`ASSERT_IMPLY(a_data_len, clk, arst_n, phase_q == PH_DATA, len_q != '0)
	`ASSERT_IMPLY(a_line_start, clk, arst_n, line_start_q, phase_q == PH_SIZE)
	`ASSERT_NEXT(a_data_class, clk, arst_n, s_accept && phase_q == PH_DATA,
		m_tvalid && m_tuser == CL_DATA)
	`ASSERT_IMPLY(a_final_done, clk, arst_n, m_tvalid && m_tuser == CL_FINAL,
		phase_q == PH_DONE)

endmodule

`default_nettype wire
